@@ sv/ppm_frame_decoder_defines.svh @@
// assertion macros for the checker file of the ppm frame decoder
`ifndef PPM_FRAME_DECODER_DEFINES_SVH
`define PPM_FRAME_DECODER_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define PPM_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("ppm frame decoder check failed");

// next-cycle implication, quiet while reset is asserted
`define PPM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("ppm frame decoder check failed");

`endif

@@ sv/ppm_pkg.sv @@
// types and constants of the ppm frame decoder
`timescale 1ns / 1ps
`default_nettype none

package ppm_pkg;

	localparam int TICK_W  = 16;
	localparam int IDX_W   = 4;
	localparam int GAIN_W  = 10;
	localparam int VALUE_W = 21;
	localparam int PROD_W  = GAIN_W + TICK_W;
	localparam int QUO_W   = VALUE_W - 1;

	// floor(m / 100) == (m * RECIP_MUL) >> RECIP_SHIFT for every m below 2**30
	localparam int RECIP_SHIFT = 33;
	localparam int RECIP_W     = 27;
	localparam logic [RECIP_W-1:0] RECIP_MUL = 27'd85899346;
	localparam int RPROD_W     = PROD_W + RECIP_W;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_GAIN          = 2'd0;
	localparam cfg_idx_t CFG_CENTER_OFFSET = 2'd1;
	localparam cfg_idx_t CFG_SYNC_LIMIT    = 2'd2;

	localparam logic [GAIN_W-1:0] GAIN_RST   = 10'd244;
	localparam logic [TICK_W-1:0] OFFSET_RST = 16'd1220;
	localparam logic [TICK_W-1:0] SYNC_RST   = 16'd4000;

	// one channel pulse on its way to scaling: sign and magnitude of interval - offset
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic              neg;
		logic [TICK_W-1:0] mag;
	} pulse_t;

endpackage

`default_nettype wire

@@ sv/ppm_frame_decoder.sv @@
// top level of the ppm frame decoder
//
// channel   direction  handshake           payload
// --------  ---------  ------------------  -----------------------------
// in        sink       in_valid/in_stall   ppm_level
// out       source     out_valid/out_stall channel_index, channel_value
// cfg       sink       cfg_we              cfg_index, cfg_wdata
//
// one line sample word is taken per cycle while in_stall is low; the
// tick counter and edge logic update in the cycle the word is accepted
// a channel value is computed from its sample in these steps:
// offset subtract, gain multiply, reciprocal multiply for the divide by 100,
// sign restore, one register after each step
// out_stall freezes only stages that are full; in_stall rises only when all
// four stages hold a word and the output is stalled
// arst_n clears the line history, tick counter, channel index, pipeline valids
// and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none

module ppm_frame_decoder
	import ppm_pkg::*;
#(
	parameter int NUM_CHANNELS = 9
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 ppm_level,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [IDX_W-1:0]          channel_index,
	output logic signed [VALUE_W-1:0] channel_value,
	input  wire logic                 cfg_we,
	input  wire cfg_idx_t             cfg_index,
	input  wire logic [TICK_W-1:0]    cfg_wdata
);

	// configuration registers
	logic [GAIN_W-1:0] gain_q;
	logic [TICK_W-1:0] center_offset_q;
	logic [TICK_W-1:0] sync_limit_q;

	logic   scale_ready;
	logic   take;
	logic   emit;
	pulse_t pulse;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q          <= GAIN_RST;
			center_offset_q <= OFFSET_RST;
			sync_limit_q    <= SYNC_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN:          gain_q          <= cfg_wdata[GAIN_W-1:0];
				CFG_CENTER_OFFSET: center_offset_q <= cfg_wdata;
				CFG_SYNC_LIMIT:    sync_limit_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// a sample word is only taken when the scaling pipe can absorb a result
	assign in_stall = ~scale_ready;
	assign take     = in_valid & scale_ready;

	ppm_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.level        (ppm_level),
		.center_offset(center_offset_q),
		.sync_limit   (sync_limit_q),
		.emit         (emit),
		.pulse        (pulse)
	);

	ppm_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain     (gain_q),
		.up_valid (emit),
		.up_pulse (pulse),
		.up_ready (scale_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_idx  (channel_index),
		.out_value(channel_value)
	);

endmodule

`default_nettype wire

@@ sv/ppm_front.sv @@
// edge detection, interval counter and channel index tracking
`timescale 1ns / 1ps
`default_nettype none

module ppm_front
	import ppm_pkg::*;
#(
	parameter int NUM_CHANNELS = 9
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire logic              level,
	input  wire logic [TICK_W-1:0] center_offset,
	input  wire logic [TICK_W-1:0] sync_limit,
	output logic                   emit,
	output pulse_t                 pulse
);

	logic              last_level_q;
	logic [TICK_W-1:0] tick_q;
	logic [IDX_W-1:0]  chan_q;
	logic              rise;
	logic              fall;
	logic              is_sync;
	logic              chan_open;

	assign rise      = level & ~last_level_q;
	assign fall      = ~level & last_level_q;
	assign is_sync   = tick_q > sync_limit;
	assign chan_open = chan_q < IDX_W'(NUM_CHANNELS);
	assign emit      = take & rise & ~is_sync & chan_open;

	always_comb begin
		pulse.idx = chan_q;
		pulse.neg = tick_q < center_offset;
		if (pulse.neg) begin
			pulse.mag = center_offset - tick_q;
		end else begin
			pulse.mag = tick_q - center_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			tick_q       <= '0;
			chan_q       <= '0;
		end else if (take) begin
			last_level_q <= level;
			if (fall) begin
				tick_q <= '0;
			end else if (tick_q != TICK_MAX) begin
				tick_q <= tick_q + 1'b1;
			end
			if (rise && is_sync) begin
				chan_q <= '0;
			end else if (rise && chan_open) begin
				chan_q <= chan_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/ppm_scale.sv @@
// gain multiply, divide by 100 and sign restore, with per-stage flow control
`timescale 1ns / 1ps
`default_nettype none

module ppm_scale
	import ppm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [GAIN_W-1:0]  gain,
	input  wire logic               up_valid,
	input  wire pulse_t             up_pulse,
	output logic                    up_ready,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [IDX_W-1:0]        out_idx,
	output logic signed [VALUE_W-1:0] out_value
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	pulse_t             pulse_s1;
	logic [IDX_W-1:0]   idx_s2, idx_s3;
	logic               neg_s2, neg_s3;
	logic [PROD_W-1:0]  prod_s2;
	logic [QUO_W-1:0]   quo_s3;
	logic [RPROD_W-1:0] rprod;
	logic [PROD_W-1:0]  prod;

	// a stage takes a word when it is empty or its own word moves on
	assign rdy_s4   = ~v_s4 | ~out_stall;
	assign rdy_s3   = ~v_s3 | rdy_s4;
	assign rdy_s2   = ~v_s2 | rdy_s3;
	assign rdy_s1   = ~v_s1 | rdy_s2;
	assign up_ready = rdy_s1;

	assign prod  = PROD_W'(gain) * PROD_W'(pulse_s1.mag);
	assign rprod = RPROD_W'(prod_s2) * RPROD_W'(RECIP_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= up_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			pulse_s1 <= up_pulse;
		end
		if (rdy_s2 && v_s1) begin
			idx_s2  <= pulse_s1.idx;
			neg_s2  <= pulse_s1.neg;
			prod_s2 <= prod;
		end
		if (rdy_s3 && v_s2) begin
			idx_s3 <= idx_s2;
			neg_s3 <= neg_s2;
			quo_s3 <= rprod[RECIP_SHIFT +: QUO_W];
		end
		if (rdy_s4 && v_s3) begin
			out_idx <= idx_s3;
			if (neg_s3) begin
				out_value <= -$signed({1'b0, quo_s3});
			end else begin
				out_value <= $signed({1'b0, quo_s3});
			end
		end
	end

	assign out_valid = v_s4;

endmodule

`default_nettype wire

@@ sv/ppm_frame_decoder_chk.sv @@
// port-level checks of the ppm frame decoder and their bind
`timescale 1ns / 1ps
`default_nettype none
`include "ppm_frame_decoder_defines.svh"

module ppm_frame_decoder_chk
	import ppm_pkg::*;
#(
	parameter int NUM_CHANNELS = 9
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_stall,
	input wire logic                 out_valid,
	input wire logic                 out_stall,
	input wire logic [IDX_W-1:0]     channel_index,
	input wire logic signed [VALUE_W-1:0] channel_value
);

	// largest magnitude is 1023 * 65535 / 100
	localparam logic signed [VALUE_W-1:0] VALUE_LIMIT = 21'sd670423;

	`PPM_ASSERT_IMPLY(a_index_range, clk, arst_n, out_valid, channel_index < IDX_W'(NUM_CHANNELS))
	`PPM_ASSERT_IMPLY(a_value_range, clk, arst_n, out_valid, (channel_value <= VALUE_LIMIT) && (channel_value >= -VALUE_LIMIT))
	`PPM_ASSERT_IMPLY(a_stall_only_when_full, clk, arst_n, in_stall, out_valid && out_stall)
	`PPM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(channel_index) && $stable(channel_value))

endmodule

bind ppm_frame_decoder ppm_frame_decoder_chk #(
	.NUM_CHANNELS(NUM_CHANNELS)
) u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.channel_index(channel_index),
	.channel_value(channel_value)
);

`default_nettype wire
